@@ hw/rtl/pqad_pkg.sv @@
package pqad_pkg;

    localparam int CENTROIDS = 256;
    localparam int CODE_W    = 8;

    typedef enum logic [1:0] {
        OP_CODEBOOK = 2'd0,
        OP_BOUNDARY = 2'd1,
        OP_QUERY    = 2'd2,
        OP_CODE     = 2'd3
    } op_t;

    typedef enum logic [0:0] {
        CFG_METRIC = 1'd0,
        CFG_CHUNKS = 1'd1
    } cfg_idx_t;

    typedef struct packed {
        op_t         op;
        logic        wr_ok;
        logic [7:0]  centroid_index;
        logic [6:0]  dim_index;
        logic [6:0]  boundary_index;
        logic [7:0]  boundary_dim;
        logic [31:0] word_value;
        logic [7:0]  code_byte;
    } item_t;

    typedef struct packed {
        logic [1:0] out_cnt;
        logic       out_push;
        logic       out_pop;
    } back_sts_t;

    localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] FP_QUIET_BIT   = 32'h0040_0000;

    function automatic logic [31:0] fp_round_pack(input logic s, input int e,
                                                  input logic [49:0] sig);
        int          sh;
        int          ee;
        logic [73:0] w;
        logic [73:0] x;
        logic        lost;
        logic [23:0] m;
        logic        g;
        logic        st;
        logic        inc;
        logic [32:0] v;
        sh = (e < 1) ? 1 - e : 0;
        if (sh > 60)
            sh = 60;
        w    = {sig, 24'b0};
        x    = w >> sh;
        lost = ((x << sh) != w);
        m    = x[73:50];
        g    = x[49];
        st   = (|x[48:0]) | lost;
        inc  = g & (st | m[0]);
        ee   = (e < 1) ? 1 : e;
        v    = (33'(ee - 1) << 23) + 33'(m) + 33'(inc);
        if (v >= (33'(255) << 23))
            return {s, 8'hFF, 23'b0};
        return {s, v[30:0]};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic        s;
        logic        an, bn, ai, bi, az, bz;
        logic [23:0] ma, mb;
        int          xa, xb, k;
        logic [47:0] p;
        logic [49:0] sig;
        s  = a[31] ^ b[31];
        an = (a[30:23] == 8'hFF) && (a[22:0] != 23'b0);
        bn = (b[30:23] == 8'hFF) && (b[22:0] != 23'b0);
        ai = (a[30:23] == 8'hFF) && (a[22:0] == 23'b0);
        bi = (b[30:23] == 8'hFF) && (b[22:0] == 23'b0);
        az = (a[30:0] == 31'b0);
        bz = (b[30:0] == 31'b0);
        if (an)
            return a | FP_QUIET_BIT;
        if (bn)
            return b | FP_QUIET_BIT;
        if ((ai && bz) || (bi && az))
            return FP_DEFAULT_NAN;
        if (ai || bi)
            return {s, 8'hFF, 23'b0};
        if (az || bz)
            return {s, 31'b0};
        ma = {(a[30:23] != 8'b0), a[22:0]};
        mb = {(b[30:23] != 8'b0), b[22:0]};
        xa = (a[30:23] == 8'b0) ? 1 : int'(a[30:23]);
        xb = (b[30:23] == 8'b0) ? 1 : int'(b[30:23]);
        p  = ma * mb;
        k  = 0;
        for (int i = 0; i < 48; i++)
            if (p[i])
                k = i;
        sig = {p, 2'b0} << (47 - k);
        return fp_round_pack(s, k + xa + xb - 173, sig);
    endfunction

    function automatic logic [31:0] fp_addsub(input logic [31:0] a, input logic [31:0] b,
                                              input logic sub);
        logic [31:0] bv;
        logic [31:0] x;
        logic [31:0] y;
        logic        an, bn, ai, bi, az, bz;
        logic [49:0] xs, yf, ys, r;
        int          xe, ye, d, k;
        logic        lost;
        bv = b ^ {sub, 31'b0};
        an = (a[30:23] == 8'hFF) && (a[22:0] != 23'b0);
        bn = (b[30:23] == 8'hFF) && (b[22:0] != 23'b0);
        ai = (a[30:23] == 8'hFF) && (a[22:0] == 23'b0);
        bi = (b[30:23] == 8'hFF) && (b[22:0] == 23'b0);
        az = (a[30:0] == 31'b0);
        bz = (b[30:0] == 31'b0);
        if (an)
            return a | FP_QUIET_BIT;
        if (bn)
            return b | FP_QUIET_BIT;
        if (ai && bi)
            return (a[31] != bv[31]) ? FP_DEFAULT_NAN : a;
        if (ai)
            return a;
        if (bi)
            return bv;
        if (az && bz)
            return {a[31] & bv[31], 31'b0};
        if (az)
            return bv;
        if (bz)
            return a;
        if (a[30:0] >= bv[30:0])
        begin
            x = a;
            y = bv;
        end
        else
        begin
            x = bv;
            y = a;
        end
        xe   = (x[30:23] == 8'b0) ? 1 : int'(x[30:23]);
        ye   = (y[30:23] == 8'b0) ? 1 : int'(y[30:23]);
        d    = xe - ye;
        xs   = {1'b0, (x[30:23] != 8'b0), x[22:0], 25'b0};
        yf   = {1'b0, (y[30:23] != 8'b0), y[22:0], 25'b0};
        ys   = yf >> d;
        lost = ((ys << d) != yf);
        ys[0] = ys[0] | lost;
        r = (x[31] != y[31]) ? xs - ys : xs + ys;
        if (r == 50'b0)
            return 32'b0;
        k = 0;
        for (int i = 0; i < 50; i++)
            if (r[i])
                k = i;
        return fp_round_pack(x[31], xe + k - 48, r << (49 - k));
    endfunction

endpackage

@@ hw/rtl/pq_asymmetric_distance_unit.sv @@
// Sequence: the back end takes a write transaction while idle; a code byte
// goes through a boundary state, then read, subtract, multiply and accumulate per
// dimension of its chunk, then a final state that holds while the result queue
// is full; no new item is taken until it ends. A two-entry queue decouples input.
// Reset: asynchronous, active low; clears queues, sum and chunk count.
module pq_asymmetric_distance_unit #(
    parameter int MAX_DIMS   = 128,
    parameter int MAX_CHUNKS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  operation,
    input  logic [7:0]  centroid_index,
    input  logic [6:0]  dim_index,
    input  logic [6:0]  boundary_index,
    input  logic [7:0]  boundary_dim,
    input  logic [31:0] word_value,
    input  logic [7:0]  code_byte,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] distance,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);

    logic                item_vld;
    logic                item_take;
    pqad_pkg::item_t     item;
    pqad_pkg::back_sts_t sts;

    pqad_front #(.MAX_DIMS(MAX_DIMS), .MAX_CHUNKS(MAX_CHUNKS)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .operation      (operation),
        .centroid_index (centroid_index),
        .dim_index      (dim_index),
        .boundary_index (boundary_index),
        .boundary_dim   (boundary_dim),
        .word_value     (word_value),
        .code_byte      (code_byte),
        .item_vld       (item_vld),
        .item           (item),
        .item_take      (item_take)
    );

    pqad_back #(.MAX_DIMS(MAX_DIMS), .MAX_CHUNKS(MAX_CHUNKS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_vld  (item_vld),
        .item      (item),
        .item_take (item_take),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .empty     (empty),
        .pop       (pop),
        .distance  (distance),
        .sts       (sts)
    );

    a_out_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        sts.out_cnt != 2'd3)
        else $error("result queue count out of range");

    a_last_pop_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (sts.out_pop && sts.out_cnt == 2'd1 && !sts.out_push) |=> empty)
        else $error("result queue not empty after last transaction");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        sts.out_push |=> !empty)
        else $error("result lost after push");

endmodule

@@ hw/rtl/pqad_ram.sv @@
module pqad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/pqad_front.sv @@
module pqad_front #(
    parameter int MAX_DIMS   = 128,
    parameter int MAX_CHUNKS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          operation,
    input  logic [7:0]          centroid_index,
    input  logic [6:0]          dim_index,
    input  logic [6:0]          boundary_index,
    input  logic [7:0]          boundary_dim,
    input  logic [31:0]         word_value,
    input  logic [7:0]          code_byte,
    output logic                item_vld,
    output pqad_pkg::item_t     item,
    input  logic                item_take
);

    pqad_pkg::item_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      cnt_reg;
    logic [1:0]      cnt_next;
    pqad_pkg::item_t cls;
    logic            do_push;
    logic            do_pop;

    always_comb
    begin
        cls.op             = pqad_pkg::op_t'(operation);
        cls.centroid_index = centroid_index;
        cls.dim_index      = dim_index;
        cls.boundary_index = boundary_index;
        cls.boundary_dim   = boundary_dim;
        cls.word_value     = word_value;
        cls.code_byte      = code_byte;
        case (cls.op)
            pqad_pkg::OP_CODEBOOK: cls.wr_ok = 32'(dim_index) < MAX_DIMS;
            pqad_pkg::OP_QUERY:    cls.wr_ok = 32'(dim_index) < MAX_DIMS;
            pqad_pkg::OP_BOUNDARY: cls.wr_ok = 32'(boundary_index) <= MAX_CHUNKS;
            default:               cls.wr_ok = 1'b1;
        endcase
    end

    assign full     = (cnt_reg == 2'd2);
    assign do_push  = push && !full;
    assign item_vld = (cnt_reg != 2'd0);
    assign do_pop   = item_take && item_vld;
    assign item     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 2'd1;
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ hw/rtl/pqad_back.sv @@
module pqad_back #(
    parameter int MAX_DIMS   = 128,
    parameter int MAX_CHUNKS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_vld,
    input  pqad_pkg::item_t       item,
    output logic                  item_take,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [6:0]            cfg_data,
    output logic                  empty,
    input  logic                  pop,
    output logic [31:0]           distance,
    output pqad_pkg::back_sts_t   sts
);

    localparam int DAW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int JW   = $clog2(MAX_DIMS + 1);
    localparam int CW   = $clog2(MAX_CHUNKS + 1);
    localparam int CBAW = DAW + pqad_pkg::CODE_W;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_BND  = 7'b0000010,
        ST_READ = 7'b0000100,
        ST_SUB  = 7'b0001000,
        ST_MUL  = 7'b0010000,
        ST_ACC  = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

    state_t         state_reg, state_next;
    logic           metric_reg;
    logic [6:0]     chunks_reg;
    logic [31:0]    acc_reg, acc_next;
    logic [31:0]    diff_reg;
    logic [31:0]    term_reg;
    logic [CW-1:0]  chunk_reg, chunk_next;
    logic [CW-1:0]  chk_reg;
    logic [7:0]     code_reg;
    logic [JW-1:0]  j_reg, j_next;
    logic [JW-1:0]  end_reg;
    logic [31:0]    out_mem_reg [2];
    logic           out_wr_reg;
    logic           out_rd_reg;
    logic [1:0]     out_cnt_reg;

    logic [CW-1:0]  chk_cur;
    logic [CW-1:0]  cnt1;
    logic [31:0]    lim;
    logic [JW-1:0]  start_d, end_d;
    logic [7:0]     b0_rd, b1_rd;
    logic [31:0]    c_rd, q_rd;
    logic           out_push, out_pop;
    logic           op_cb, op_bnd, op_q, op_code;
    logic [31:0]    mul_a, mul_b;

    function automatic logic [JW-1:0] clamp_dim(input logic [7:0] d);
        if (32'(d) > MAX_DIMS)
            return JW'(MAX_DIMS);
        return JW'(d);
    endfunction

    assign op_cb   = (state_reg == ST_IDLE) && item_vld && (item.op == pqad_pkg::OP_CODEBOOK)
                     && item.wr_ok;
    assign op_bnd  = (state_reg == ST_IDLE) && item_vld && (item.op == pqad_pkg::OP_BOUNDARY)
                     && item.wr_ok;
    assign op_q    = (state_reg == ST_IDLE) && item_vld && (item.op == pqad_pkg::OP_QUERY)
                     && item.wr_ok;
    assign op_code = (state_reg == ST_IDLE) && item_vld && (item.op == pqad_pkg::OP_CODE);
    assign item_take = (state_reg == ST_IDLE);

    assign chk_cur = (32'(chunk_reg) >= MAX_CHUNKS) ? CW'(MAX_CHUNKS - 1) : chunk_reg;
    assign cnt1    = chk_reg + CW'(1);
    assign lim     = (chunks_reg == 7'd0) ? 32'd1 :
                     (32'(chunks_reg) > MAX_CHUNKS) ? 32'(MAX_CHUNKS) : 32'(chunks_reg);
    assign start_d = clamp_dim(b0_rd);
    assign end_d   = clamp_dim(b1_rd);
    assign mul_a   = metric_reg ? c_rd : diff_reg;
    assign mul_b   = metric_reg ? q_rd : diff_reg;

    pqad_ram #(.WIDTH(32), .DEPTH(MAX_DIMS * pqad_pkg::CENTROIDS)) u_codebook (
        .clk   (clk),
        .we    (op_cb),
        .waddr ({DAW'(item.dim_index), item.centroid_index}),
        .wdata (item.word_value),
        .re    (state_reg == ST_READ),
        .raddr (CBAW'({j_reg[DAW-1:0], code_reg})),
        .rdata (c_rd)
    );

    pqad_ram #(.WIDTH(32), .DEPTH(MAX_DIMS)) u_query (
        .clk   (clk),
        .we    (op_q),
        .waddr (DAW'(item.dim_index)),
        .wdata (item.word_value),
        .re    (state_reg == ST_READ),
        .raddr (j_reg[DAW-1:0]),
        .rdata (q_rd)
    );

    pqad_ram #(.WIDTH(8), .DEPTH(MAX_CHUNKS + 1)) u_bound_lo (
        .clk   (clk),
        .we    (op_bnd),
        .waddr (CW'(item.boundary_index)),
        .wdata (item.boundary_dim),
        .re    (op_code),
        .raddr (chk_cur),
        .rdata (b0_rd)
    );

    pqad_ram #(.WIDTH(8), .DEPTH(MAX_CHUNKS + 1)) u_bound_hi (
        .clk   (clk),
        .we    (op_bnd),
        .waddr (CW'(item.boundary_index)),
        .wdata (item.boundary_dim),
        .re    (op_code),
        .raddr (chk_cur + CW'(1)),
        .rdata (b1_rd)
    );

    assign out_pop  = pop && !empty;
    assign empty    = (out_cnt_reg == 2'd0);
    assign distance = out_mem_reg[out_rd_reg];

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        chunk_next = chunk_reg;
        j_next     = j_reg;
        out_push   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (op_code)
                    state_next = ST_BND;
            end
            ST_BND:
            begin
                j_next     = start_d;
                state_next = (start_d < end_d) ? ST_READ : ST_FIN;
            end
            ST_READ: state_next = ST_SUB;
            ST_SUB:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_ACC;
            ST_ACC:
            begin
                acc_next   = pqad_pkg::fp_addsub(acc_reg, term_reg, 1'b0);
                j_next     = j_reg + JW'(1);
                state_next = (j_next < end_reg) ? ST_READ : ST_FIN;
            end
            ST_FIN:
            begin
                if (32'(cnt1) >= lim)
                begin
                    if (out_cnt_reg != 2'd2)
                    begin
                        out_push   = 1'b1;
                        acc_next   = 32'b0;
                        chunk_next = '0;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    chunk_next = cnt1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (op_code)
        begin
            code_reg <= item.code_byte;
            chk_reg  <= chk_cur;
        end
        if (state_reg == ST_BND)
            end_reg <= end_d;
        if (state_reg == ST_SUB)
            diff_reg <= pqad_pkg::fp_addsub(c_rd, q_rd, 1'b1);
        if (state_reg == ST_MUL)
            term_reg <= pqad_pkg::fp_mul(mul_a, mul_b);
        j_reg <= j_next;
        if (out_push)
            out_mem_reg[out_wr_reg] <= acc_reg ^ {metric_reg, 31'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            metric_reg  <= 1'b0;
            chunks_reg  <= 7'd32;
            acc_reg     <= 32'b0;
            chunk_reg   <= '0;
            out_wr_reg  <= 1'b0;
            out_rd_reg  <= 1'b0;
            out_cnt_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            chunk_reg <= chunk_next;
            if (cfg_we)
            begin
                case (pqad_pkg::cfg_idx_t'(cfg_index))
                    pqad_pkg::CFG_METRIC: metric_reg <= cfg_data[0];
                    pqad_pkg::CFG_CHUNKS: chunks_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_push)
                out_wr_reg <= !out_wr_reg;
            if (out_pop)
                out_rd_reg <= !out_rd_reg;
            if (out_push && !out_pop)
                out_cnt_reg <= out_cnt_reg + 2'd1;
            else if (!out_push && out_pop)
                out_cnt_reg <= out_cnt_reg - 2'd1;
        end
    end

    assign sts.out_cnt  = out_cnt_reg;
    assign sts.out_push = out_push;
    assign sts.out_pop  = out_pop;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import pqad_pkg::*;

    localparam int MAX_DIMS   = 128;
    localparam int MAX_CHUNKS = 64;
    localparam int DRAIN      = 2000;

    typedef struct {
        op_t         op;
        logic [7:0]  cidx;
        logic [6:0]  dim;
        logic [6:0]  bidx;
        logic [7:0]  bdim;
        logic [31:0] word;
        logic [7:0]  code;
        bit          chk;
        logic [31:0] want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  operation;
    logic [7:0]  centroid_index;
    logic [6:0]  dim_index;
    logic [6:0]  boundary_index;
    logic [7:0]  boundary_dim;
    logic [31:0] word_value;
    logic [7:0]  code_byte;
    logic        empty;
    logic        pop;
    logic [31:0] distance;
    logic        cfg_we;
    logic        cfg_index;
    logic [6:0]  cfg_data;

    logic [31:0] cb_mem [0:MAX_DIMS*CENTROIDS-1];
    bit          cb_wr  [0:MAX_DIMS*CENTROIDS-1];
    logic [31:0] q_mem  [0:MAX_DIMS-1];
    bit          q_wr   [0:MAX_DIMS-1];
    logic [7:0]  bnd    [0:MAX_CHUNKS];
    logic [31:0] acc_bits;
    int          chunk_cnt;
    bit          mode_r;
    logic [6:0]  chunks_r;

    logic [31:0] dist_q [$];
    stim_row_t   dir_rows [$];
    int          errors;
    int          sent;
    bit          no_idle;
    bit          hold_req;

    pq_asymmetric_distance_unit u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .operation(operation),
        .centroid_index(centroid_index), .dim_index(dim_index),
        .boundary_index(boundary_index), .boundary_dim(boundary_dim),
        .word_value(word_value), .code_byte(code_byte), .empty(empty), .pop(pop),
        .distance(distance), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit fl_is_nan(logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] != 23'b0);
    endfunction

    function automatic bit fl_is_inf(logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] == 23'b0);
    endfunction

    function automatic real fl_to_real(logic [31:0] f);
        logic [63:0] d;
        real         r;
        if (f[30:0] == 31'b0)
            return $bitstoreal({f[31], 63'b0});
        if (f[30:23] == 8'hFF)
            return $bitstoreal({f[31], 11'h7FF, 52'b0});
        if (f[30:23] == 8'b0)
        begin
            r = real'(f[22:0]) * $bitstoreal({1'b0, 11'd874, 52'b0});
            return f[31] ? -r : r;
        end
        d = {f[31], 11'(int'(f[30:23]) + 896), f[22:0], 29'b0};
        return $bitstoreal(d);
    endfunction

    function automatic logic [31:0] real_to_fl(real r);
        logic [63:0] d;
        logic [63:0] sig;
        logic [63:0] rem;
        logic [63:0] half;
        int          e;
        int          sh;
        logic        s;
        d = $realtobits(r);
        s = d[63];
        if (d[62:0] == 63'b0)
            return {s, 31'b0};
        e = int'(d[62:52]) - 1023;
        if (e > 127)
            return {s, 8'hFF, 23'b0};
        sig = {11'b0, 1'b1, d[51:0]};
        sh  = (e >= -126) ? 29 : 29 + (-126 - e);
        if (sh > 60)
            return {s, 31'b0};
        half = 64'd1 << (sh - 1);
        rem  = sig & ((64'd1 << sh) - 64'd1);
        sig  = sig >> sh;
        if (rem > half || (rem == half && sig[0]))
            sig = sig + 64'd1;
        if (e < -126)
            return {s, 31'(sig)};
        if (sig[24])
        begin
            sig = sig >> 1;
            e++;
        end
        if (e > 127)
            return {s, 8'hFF, 23'b0};
        return {s, 8'(e + 127), sig[22:0]};
    endfunction

    function automatic logic [31:0] fl_mul(logic [31:0] a, logic [31:0] b);
        if (fl_is_nan(a))
            return a | FP_QUIET_BIT;
        if (fl_is_nan(b))
            return b | FP_QUIET_BIT;
        if ((fl_is_inf(a) && b[30:0] == 31'b0) || (fl_is_inf(b) && a[30:0] == 31'b0))
            return FP_DEFAULT_NAN;
        return real_to_fl(fl_to_real(a) * fl_to_real(b));
    endfunction

    function automatic logic [31:0] fl_add(logic [31:0] a, logic [31:0] b, logic neg);
        logic [31:0] bn;
        if (fl_is_nan(a))
            return a | FP_QUIET_BIT;
        if (fl_is_nan(b))
            return b | FP_QUIET_BIT;
        bn = b ^ {neg, 31'b0};
        if (fl_is_inf(a) && fl_is_inf(bn) && a[31] != bn[31])
            return FP_DEFAULT_NAN;
        return real_to_fl(fl_to_real(a) + fl_to_real(bn));
    endfunction

    function automatic int clamp_dim(int v);
        return (v > MAX_DIMS) ? MAX_DIMS : v;
    endfunction

    // Advance the distance state by one transaction.
    task automatic apply_item(input stim_row_t r, output bit has, output logic [31:0] val);
        int          lim;
        int          ch;
        int          lo;
        int          hi;
        logic [31:0] c;
        logic [31:0] q;
        logic [31:0] t;
        has = 1'b0;
        val = 32'b0;
        case (r.op)
            OP_CODEBOOK:
            begin
                cb_mem[{r.dim, r.cidx}] = r.word;
                cb_wr[{r.dim, r.cidx}]  = 1'b1;
            end
            OP_BOUNDARY:
            begin
                if (r.bidx <= MAX_CHUNKS)
                    bnd[r.bidx] = r.bdim;
            end
            OP_QUERY:
            begin
                q_mem[r.dim] = r.word;
                q_wr[r.dim]  = 1'b1;
            end
            default:
            begin
                lim = (chunks_r == 0) ? 1 : (chunks_r > MAX_CHUNKS) ? MAX_CHUNKS : chunks_r;
                ch  = (chunk_cnt >= MAX_CHUNKS) ? MAX_CHUNKS - 1 : chunk_cnt;
                lo  = clamp_dim(bnd[ch]);
                hi  = clamp_dim(bnd[ch + 1]);
                for (int j = lo; j < hi; j++)
                begin
                    c = cb_mem[j * CENTROIDS + r.code];
                    q = q_mem[j];
                    if (mode_r)
                        t = fl_mul(c, q);
                    else
                    begin
                        t = fl_add(c, q, 1'b1);
                        t = fl_mul(t, t);
                    end
                    acc_bits = fl_add(acc_bits, t, 1'b0);
                end
                chunk_cnt = ch + 1;
                if (chunk_cnt >= lim)
                begin
                    has       = 1'b1;
                    val       = acc_bits ^ {mode_r, 31'b0};
                    acc_bits  = 32'b0;
                    chunk_cnt = 0;
                end
            end
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(0, 63);
        case (r)
            0, 1, 2: return $urandom;
            3:       return {1'($urandom), 31'b0};
            4:       return {1'($urandom), 8'hFF, 23'b0};
            5:       return {1'($urandom), 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))};
            6, 7:    return {1'($urandom), 8'h00, 23'($urandom)};
            8:       return {1'($urandom), 8'hFE, 23'h7FFFFF};
            default: return {1'($urandom), 8'($urandom_range(118, 134)), 23'($urandom)};
        endcase
    endfunction

    function automatic stim_row_t rand_row(op_t op);
        stim_row_t r;
        r.op   = op;
        r.cidx = 8'($urandom);
        r.dim  = 7'($urandom);
        r.bidx = 7'($urandom);
        r.bdim = 8'($urandom);
        r.word = rand_word();
        r.code = 8'($urandom);
        r.chk  = 1'b0;
        r.want = 32'b0;
        return r;
    endfunction

    task automatic send_row(input stim_row_t r);
        int          gap;
        bit          has;
        logic [31:0] v;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push           <= 1'b1;
        operation      <= r.op;
        centroid_index <= r.cidx;
        dim_index      <= r.dim;
        boundary_index <= r.bidx;
        boundary_dim   <= r.bdim;
        word_value     <= r.word;
        code_byte      <= r.code;
        do
            @(posedge clk);
        while (full);
        apply_item(r, has, v);
        if (has)
            dist_q.push_back(r.chk ? r.want : v);
        sent++;
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (dist_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input logic [6:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_METRIC)
            mode_r = data[0];
        else
            chunks_r = data;
    endtask

    // Fill whatever the current chunk reads, then send the code byte.
    task automatic send_code();
        stim_row_t  r;
        int         ch;
        int         lo;
        int         hi;
        logic [7:0] c;
        ch = (chunk_cnt >= MAX_CHUNKS) ? MAX_CHUNKS - 1 : chunk_cnt;
        lo = clamp_dim(bnd[ch]);
        hi = clamp_dim(bnd[ch + 1]);
        c  = 8'($urandom);
        for (int j = lo; j < hi; j++)
        begin
            if (!q_wr[j])
            begin
                r     = rand_row(OP_QUERY);
                r.dim = 7'(j);
                send_row(r);
            end
            if (!cb_wr[j * CENTROIDS + c])
            begin
                r      = rand_row(OP_CODEBOOK);
                r.dim  = 7'(j);
                r.cidx = c;
                send_row(r);
            end
        end
        r      = rand_row(OP_CODE);
        r.code = c;
        send_row(r);
    endtask

    task automatic send_noise();
        stim_row_t r;
        int        v;
        r = rand_row(op_t'($urandom_range(0, 2)));
        if (r.op == OP_BOUNDARY && r.bidx <= MAX_CHUNKS && $urandom_range(0, 19) != 0)
        begin
            v = int'(bnd[r.bidx]) + $urandom_range(0, 4) - 2;
            r.bdim = (v < 0) ? 8'd0 : (v > MAX_DIMS) ? 8'(MAX_DIMS) : 8'(v);
        end
        send_row(r);
    endtask

    task automatic run_phase(input bit metric, input logic [6:0] chunks, input int n,
                             input bit quiet, input bit setup, input bit hold);
        stim_row_t r;
        int        v;
        int        stop;
        wait_idle();
        cfg_write(CFG_METRIC, {6'($urandom), metric});
        cfg_write(CFG_CHUNKS, chunks);
        no_idle = quiet;
        stop    = sent + n;
        if (setup)
        begin
            v = 0;
            for (int k = 0; k <= MAX_CHUNKS; k++)
            begin
                r      = rand_row(OP_BOUNDARY);
                r.bidx = 7'(k);
                r.bdim = 8'(v);
                send_row(r);
                v += $urandom_range(0, 3);
            end
        end
        hold_req = hold;
        while (sent < stop)
        begin
            if ($urandom_range(0, 3) != 0)
                send_code();
            else
                send_noise();
        end
    endtask

    task automatic report(input string what);
        $display("%0t  %s", $realtime, what);
        errors++;
    endtask

    // Drain: check each popped distance, stall at random or on hold.
    initial
    begin
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (dist_q.size() == 0)
                    report($sformatf("unexpected distance %h", distance));
                else if (distance !== dist_q[0])
                begin
                    report($sformatf("distance %h, predicted %h", distance, dist_q[0]));
                    void'(dist_q.pop_front());
                end
                else
                    void'(dist_q.pop_front());
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (3000) @(posedge clk);
            end
            else if (no_idle)
                pop <= 1'b1;
            else if ($urandom_range(0, 99) < 3)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(10, 60)) @(posedge clk);
            end
            else
                pop <= ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        #200_000_000;
        $display("pq_asymmetric_distance_unit: mismatch");
        $finish;
    end

    initial
    begin
        errors    = 0;
        sent      = 0;
        no_idle   = 1'b0;
        hold_req  = 1'b0;
        acc_bits  = 32'b0;
        chunk_cnt = 0;
        mode_r    = 1'b0;
        chunks_r  = 7'd32;
        rst_n          <= 1'b0;
        push           <= 1'b0;
        operation      <= OP_CODEBOOK;
        centroid_index <= '0;
        dim_index      <= '0;
        boundary_index <= '0;
        boundary_dim   <= '0;
        word_value     <= '0;
        code_byte      <= '0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_METRIC;
        cfg_data       <= '0;

        dir_rows.push_back('{OP_BOUNDARY, 0, 0, 0, 0, 0, 0, 0, 0});
        dir_rows.push_back('{OP_BOUNDARY, 0, 0, 1, 1, 0, 0, 0, 0});
        dir_rows.push_back('{OP_QUERY, 0, 0, 0, 0, 32'h40400000, 0, 0, 0});
        dir_rows.push_back('{OP_CODEBOOK, 0, 0, 0, 0, 32'h3F800000, 0, 0, 0});
        dir_rows.push_back('{OP_CODE, 0, 0, 0, 0, 0, 0, 1, 32'h40800000});
        dir_rows.push_back('{OP_CODEBOOK, 255, 0, 0, 0, 32'h7F800000, 0, 0, 0});
        dir_rows.push_back('{OP_CODE, 0, 0, 0, 0, 0, 255, 1, 32'h7F800000});
        dir_rows.push_back('{OP_QUERY, 0, 0, 0, 0, 32'h7F800000, 0, 0, 0});
        dir_rows.push_back('{OP_CODEBOOK, 1, 0, 0, 0, 32'h7F800000, 0, 0, 0});
        dir_rows.push_back('{OP_CODE, 0, 0, 0, 0, 0, 1, 1, FP_DEFAULT_NAN});
        dir_rows.push_back('{OP_QUERY, 0, 0, 0, 0, 32'h7F800001, 0, 0, 0});
        dir_rows.push_back('{OP_CODE, 0, 0, 0, 0, 0, 0, 1, 32'h7FC00001});
        dir_rows.push_back('{OP_QUERY, 0, 0, 0, 0, 32'h00000001, 0, 0, 0});
        dir_rows.push_back('{OP_CODEBOOK, 2, 0, 0, 0, 32'h80000000, 0, 0, 0});
        dir_rows.push_back('{OP_CODE, 0, 0, 0, 0, 0, 2, 1, 32'h00000000});
        dir_rows.push_back('{OP_BOUNDARY, 0, 0, 1, 0, 0, 0, 0, 0});
        dir_rows.push_back('{OP_CODE, 0, 0, 0, 0, 0, 0, 1, 32'h00000000});
        dir_rows.push_back('{OP_BOUNDARY, 0, 0, 127, 255, 0, 0, 0, 0});
        dir_rows.push_back('{OP_BOUNDARY, 0, 0, 64, 128, 0, 0, 0, 0});
        dir_rows.push_back('{OP_QUERY, 0, 127, 0, 0, 32'h7F7FFFFF, 0, 0, 0});
        dir_rows.push_back('{OP_CODEBOOK, 255, 127, 0, 0, 32'hFF7FFFFF, 0, 0, 0});
        dir_rows.push_back('{OP_BOUNDARY, 0, 0, 1, 1, 0, 0, 0, 0});
        dir_rows.push_back('{OP_CODEBOOK, 3, 0, 0, 0, 32'h7F7FFFFF, 0, 0, 0});
        dir_rows.push_back('{OP_CODE, 0, 0, 0, 0, 0, 3, 1, 32'h7F800000});
        dir_rows.push_back('{OP_CODE, 0, 0, 0, 0, 0, 0, 0, 0});

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        cfg_write(CFG_METRIC, 7'd0);
        cfg_write(CFG_CHUNKS, 7'd1);
        foreach (dir_rows[i])
            send_row(dir_rows[i]);

        run_phase(1'b0, 7'd64, 330, 1'b0, 1'b1, 1'b0);
        run_phase(1'b1, 7'd0, 330, 1'b0, 1'b0, 1'b1);
        run_phase(1'b1, 7'd127, 330, 1'b1, 1'b0, 1'b0);
        run_phase(1'b0, 7'd3, 330, 1'b0, 1'b0, 1'b0);
        run_phase(1'b1, 7'd8, 330, 1'b0, 1'b0, 1'b0);
        run_phase(1'b0, 7'd1, 330, 1'b0, 1'b0, 1'b0);
        wait_idle();

        if (errors == 0)
            $display("pq_asymmetric_distance_unit: match");
        else
            $display("pq_asymmetric_distance_unit: mismatch");
        $finish;
    end

endmodule

@@ pq_asymmetric_distance_unit.f @@
hw/rtl/pqad_pkg.sv
hw/rtl/pqad_ram.sv
hw/rtl/pqad_front.sv
hw/rtl/pqad_back.sv
hw/rtl/pq_asymmetric_distance_unit.sv
bench/tb_top.sv
